[src/mips_subset_execute_core_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef MIPS_SUBSET_EXECUTE_CORE_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_CORE_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define MSC_ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define MSC_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

[src/msc_pkg.sv]
// Shared types and constants of the execute core.
`timescale 1ns / 1ps
`default_nettype none
package msc_pkg;
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    localparam logic [1:0] LOAD_NONE = 2'd0;
    localparam logic [1:0] LOAD_WORD = 2'd1;
    localparam logic [1:0] LOAD_BYTE = 2'd2;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_BGTZ  = 6'h07;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0A;
    localparam logic [5:0] OP_SLTIU = 6'h0B;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_LUI   = 6'h0F;
    localparam logic [5:0] OP_LB    = 6'h20;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SB    = 6'h28;
    localparam logic [5:0] OP_SW    = 6'h2B;

    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    localparam logic [4:0] LINK_REG = 5'd31;
    localparam int QDEPTH = 2;
    localparam int QAW = 1;

    // Item handed from the front to the back.
    typedef struct packed {
        logic        func;
        logic [31:0] instr_word;
        logic [31:0] load_data;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic [31:0] next_pc;
        logic [1:0]  mem_op;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic [3:0]  byte_enable;
        logic        halted;
        logic        flag_n;
        logic        flag_z;
        logic        flag_v;
        logic        flag_c;
    } result_t;
endpackage
`default_nettype wire

[src/msc_fifo.sv]
// Small item queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module msc_fifo
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire msc_pkg::item_t wr_data,
    output logic                full,
    input  wire logic           rd_en,
    output msc_pkg::item_t      rd_data,
    output logic                empty
);
    msc_pkg::item_t mem_reg [msc_pkg::QDEPTH];
    logic [msc_pkg::QAW-1:0] wp_reg, rp_reg;
    logic [msc_pkg::QAW:0]   cnt_reg;

    assign full    = (cnt_reg == (msc_pkg::QAW+1)'(msc_pkg::QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (rd_en && !empty)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (msc_pkg::QAW+1)'(wr_en && !full)
                               - (msc_pkg::QAW+1)'(rd_en && !empty);
        end
    end
endmodule
`default_nettype wire

[src/msc_exec.sv]
// Back end: executes one queued item per cycle into a result register, while that register is empty or being popped.
`timescale 1ns / 1ps
`default_nettype none
module msc_exec
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [31:0]    cfg_wdata,
    input  wire logic           item_valid,
    input  wire msc_pkg::item_t item,
    output logic                item_take,
    output msc_pkg::result_t    res,
    output logic                res_valid,
    input  wire logic           res_take
);
    logic [31:0] rf_reg [32];
    logic [31:0] pc_reg;
    logic        fn_reg, fz_reg, fv_reg, fc_reg, halt_reg;
    logic [1:0]  pk_reg;
    logic [4:0]  pr_reg;
    logic [1:0]  pl_reg;
    msc_pkg::result_t res_reg;
    logic        rv_reg;

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd;
    logic [31:0] a, b, imm, simm, npc, addr, jt, res_add, res_sub, wv, bv;
    logic        c_add, c_sub, ok, we;
    logic [4:0]  wa;
    logic [31:0] pc_next;
    logic        fn_next, fz_next, fv_next, fc_next, halt_next;
    logic [1:0]  pk_next, pl_next, mop;
    logic [4:0]  pr_next;
    logic [31:0] maddr, mwd;
    logic [3:0]  be;
    msc_pkg::result_t res_next;

    assign item_take = item_valid && (!rv_reg || res_take);
    assign res       = res_reg;
    assign res_valid = rv_reg;

    assign op   = item.instr_word[31:26];
    assign fn   = item.instr_word[5:0];
    assign rs   = item.instr_word[25:21];
    assign rt   = item.instr_word[20:16];
    assign rd   = item.instr_word[15:11];
    assign a    = (rs == 5'd0) ? 32'd0 : rf_reg[rs];
    assign b    = (rt == 5'd0) ? 32'd0 : rf_reg[rt];
    assign imm  = {16'd0, item.instr_word[15:0]};
    assign simm = {{16{item.instr_word[15]}}, item.instr_word[15:0]};
    assign addr = a + simm;
    assign jt   = {pc_reg[31:28], item.instr_word[25:0], 2'b00};
    assign bv   = (op == msc_pkg::OP_RTYPE) ? b : simm;
    assign {c_add, res_add} = {1'b0, a} + {1'b0, bv};
    assign res_sub = a - b;
    assign c_sub   = (b > a);

    always_comb
    begin
        pc_next = pc_reg; fn_next = fn_reg; fz_next = fz_reg;
        fv_next = fv_reg; fc_next = fc_reg; halt_next = halt_reg;
        pk_next = pk_reg; pr_next = pr_reg; pl_next = pl_reg;
        mop = msc_pkg::MEM_NONE; maddr = '0; mwd = '0; be = '0;
        we = 1'b0; wa = rt; wv = '0; ok = 1'b1; npc = pc_reg + 32'd4;
        if (!halt_reg && item.func && pk_reg != msc_pkg::LOAD_NONE)
        begin
            we = 1'b1; wa = pr_reg; wv = item.load_data;
            if (pk_reg == msc_pkg::LOAD_BYTE)
            begin
                wv = {{24{item.load_data[8*pl_reg+7]}}, item.load_data[8*pl_reg +: 8]};
            end
            pk_next = msc_pkg::LOAD_NONE; pr_next = '0; pl_next = '0;
        end
        else if (!halt_reg && !item.func && pk_reg == msc_pkg::LOAD_NONE)
        begin
            unique case (op)
                msc_pkg::OP_RTYPE:
                begin
                    wa = rd;
                    unique case (fn)
                        msc_pkg::FN_ADD, msc_pkg::FN_ADDU:
                        begin
                            we = 1'b1; wv = res_add;
                            fn_next = res_add[31]; fz_next = (res_add == '0);
                            fv_next = (~(a[31] ^ b[31])) & (a[31] ^ res_add[31]);
                            fc_next = c_add;
                        end
                        msc_pkg::FN_SUB, msc_pkg::FN_SUBU:
                        begin
                            we = 1'b1; wv = res_sub;
                            fn_next = res_sub[31]; fz_next = (res_sub == '0);
                            fv_next = (a[31] ^ b[31]) & (a[31] ^ res_sub[31]);
                            fc_next = c_sub;
                        end
                        msc_pkg::FN_SLT:
                        begin
                            we = 1'b1; wv = {31'd0, $signed(a) < $signed(b)};
                        end
                        msc_pkg::FN_SLTU:
                        begin
                            we = 1'b1; wv = {31'd0, a < b};
                        end
                        msc_pkg::FN_JR: npc = a;
                        default: ok = 1'b0;
                    endcase
                end
                msc_pkg::OP_LUI: begin we = 1'b1; wv = {item.instr_word[15:0], 16'd0}; end
                msc_pkg::OP_ORI: begin we = 1'b1; wv = a | imm; end
                msc_pkg::OP_ADDI, msc_pkg::OP_ADDIU:
                begin
                    we = 1'b1; wv = res_add;
                    fn_next = res_add[31]; fz_next = (res_add == '0);
                    fv_next = (~(a[31] ^ simm[31])) & (a[31] ^ res_add[31]);
                    fc_next = c_add;
                end
                msc_pkg::OP_SLTI: begin we = 1'b1; wv = {31'd0, $signed(a) < $signed(simm)}; end
                msc_pkg::OP_SLTIU: begin we = 1'b1; wv = {31'd0, a < imm}; end
                msc_pkg::OP_LW, msc_pkg::OP_LB:
                begin
                    mop = msc_pkg::MEM_READ; maddr = addr; pr_next = rt;
                    pk_next = (op == msc_pkg::OP_LW) ? msc_pkg::LOAD_WORD : msc_pkg::LOAD_BYTE;
                    pl_next = (op == msc_pkg::OP_LB) ? addr[1:0] : 2'd0;
                end
                msc_pkg::OP_SW:
                begin
                    mop = msc_pkg::MEM_WRITE; maddr = addr; mwd = b; be = 4'hF;
                end
                msc_pkg::OP_SB:
                begin
                    mop = msc_pkg::MEM_WRITE; maddr = addr; mwd = {4{b[7:0]}};
                    be = 4'b0001 << addr[1:0];
                end
                msc_pkg::OP_BEQ:
                begin
                    if (a == b) begin fz_next = 1'b1; npc = npc + {simm[29:0], 2'b00}; end
                end
                msc_pkg::OP_BNE:
                begin
                    if (a != b) begin fz_next = 1'b0; npc = npc + {simm[29:0], 2'b00}; end
                end
                msc_pkg::OP_BGTZ:
                begin
                    if (!a[31] && a != '0) npc = npc + {simm[29:0], 2'b00};
                end
                msc_pkg::OP_J: npc = jt;
                msc_pkg::OP_JAL: begin we = 1'b1; wa = msc_pkg::LINK_REG; wv = npc; npc = jt; end
                default: ok = 1'b0;
            endcase
            if (ok) pc_next = npc;
            else
            begin
                halt_next = 1'b1; we = 1'b0;
                fn_next = fn_reg; fz_next = fz_reg; fv_next = fv_reg; fc_next = fc_reg;
            end
        end
        res_next = '{pc_next, mop, maddr, mwd, be, halt_next,
                     fn_next, fz_next, fv_next, fc_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++) rf_reg[i] <= '0;
            pc_reg <= '0; fn_reg <= 1'b0; fz_reg <= 1'b0; fv_reg <= 1'b0;
            fc_reg <= 1'b0; halt_reg <= 1'b0; pk_reg <= msc_pkg::LOAD_NONE;
            pr_reg <= '0; pl_reg <= '0; rv_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we) pc_reg <= cfg_wdata;
            if (item_take)
            begin
                if (we && wa != 5'd0) rf_reg[wa] <= wv;
                if (!cfg_we) pc_reg <= pc_next;
                fn_reg <= fn_next; fz_reg <= fz_next; fv_reg <= fv_next;
                fc_reg <= fc_next; halt_reg <= halt_next;
                pk_reg <= pk_next; pr_reg <= pr_next; pl_reg <= pl_next;
                rv_reg <= 1'b1;
            end
            else if (res_take)
            begin
                rv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take) res_reg <= res_next;
    end
endmodule
`default_nettype wire

[src/mips_subset_execute_core.sv]
// Top level of the MIPS subset execute core.
`timescale 1ns / 1ps
`default_nettype none
// One transaction in gives one result transaction out. With pop held high an
// item is taken every cycle. An accepted item enters a two-entry input queue.
// The execute stage takes it from the queue when the result register is empty
// or being popped, and works it into that register; the result then shows on
// the ports until it is popped. A stalled pop holds the result register, the
// queue then fills, and only then does full rise. A func 0 item carries an
// instruction, a func 1 item the data of the load issued just before. The user
// must write start_pc only while idle; the block does not enforce this. A
// start_pc write also loads the program counter.
module mips_subset_execute_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start_pc_we,
    input  wire logic [31:0] start_pc_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic        func,
    input  wire logic [31:0] instr_word,
    input  wire logic [31:0] load_data,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      next_pc,
    output logic [1:0]       mem_op,
    output logic [31:0]      mem_addr,
    output logic [31:0]      mem_wdata,
    output logic [3:0]       byte_enable,
    output logic             halted,
    output logic             flag_n,
    output logic             flag_z,
    output logic             flag_v,
    output logic             flag_c
);
    msc_pkg::item_t   in_item, q_item;
    msc_pkg::result_t res;
    logic             q_empty, q_take, res_valid;

    assign in_item = '{func, instr_word, load_data};

    // Front: hold incoming transactions until the back can take them.
    msc_fifo u_fifo
    (
        .clk(clk), .rst_n(rst_n), .wr_en(push), .wr_data(in_item), .full(full),
        .rd_en(q_take), .rd_data(q_item), .empty(q_empty)
    );

    // Back: execute and hold the result until popped.
    msc_exec u_exec
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(start_pc_we), .cfg_wdata(start_pc_wdata),
        .item_valid(!q_empty), .item(q_item), .item_take(q_take),
        .res(res), .res_valid(res_valid), .res_take(pop)
    );

    assign empty       = !res_valid;
    assign next_pc     = res.next_pc;
    assign mem_op      = res.mem_op;
    assign mem_addr    = res.mem_addr;
    assign mem_wdata   = res.mem_wdata;
    assign byte_enable = res.byte_enable;
    assign halted      = res.halted;
    assign flag_n      = res.flag_n;
    assign flag_z      = res.flag_z;
    assign flag_v      = res.flag_v;
    assign flag_c      = res.flag_c;
endmodule
`default_nettype wire

[src/msc_checker.sv]
// Port-level checker for the execute core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "mips_subset_execute_core_macros.svh"
module msc_port_checks
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  mem_op,
    input wire logic [3:0]  byte_enable,
    input wire logic [31:0] mem_addr,
    input wire logic        halted
);
    `MSC_ASSERT_NOW(a_be_idle, clk, rst_n, !empty && mem_op != msc_pkg::MEM_WRITE, byte_enable == '0)
    `MSC_ASSERT_NOW(a_addr_none, clk, rst_n, !empty && mem_op == msc_pkg::MEM_NONE, mem_addr == '0)
    `MSC_ASSERT_NOW(a_op_range, clk, rst_n, !empty, mem_op != 2'd3)
    `MSC_ASSERT_NEXT(a_halt_sticky, clk, rst_n, !empty && halted && pop, empty || halted)
endmodule

bind mips_subset_execute_core msc_port_checks u_checker
(
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .mem_op(mem_op),
    .byte_enable(byte_enable), .mem_addr(mem_addr), .halted(halted)
);
`default_nettype wire

[bench/msc_checker.sv]
// Checker for the execute core: predicts each result and compares it on pop.
`timescale 1ns / 1ps
`default_nettype none
module msc_checker
    import msc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start_pc_we,
    input  wire logic [31:0] start_pc_wdata,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic        func,
    input  wire logic [31:0] instr_word,
    input  wire logic [31:0] load_data,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [31:0] next_pc,
    input  wire logic [1:0]  mem_op,
    input  wire logic [31:0] mem_addr,
    input  wire logic [31:0] mem_wdata,
    input  wire logic [3:0]  byte_enable,
    input  wire logic        halted,
    input  wire logic        flag_n,
    input  wire logic        flag_z,
    input  wire logic        flag_v,
    input  wire logic        flag_c,
    output int               fail_count,
    output int               waiting,
    output int               checked
);
    logic [31:0] gpr [32];
    logic [31:0] pc;
    logic        fn_q, fz_q, fv_q, fc_q;
    logic        halt_q;
    logic [1:0]  load_kind;
    logic [4:0]  load_reg;
    logic [1:0]  load_lane;
    result_t     due_q [$];

    assign waiting = due_q.size();

    function automatic logic [31:0] read_gpr(logic [4:0] idx);
        return (idx == 5'd0) ? 32'd0 : gpr[idx];
    endfunction

    task automatic write_gpr(logic [4:0] idx, logic [31:0] val);
        if (idx != 5'd0)
            gpr[idx] = val;
    endtask

    task automatic add_flags(logic [31:0] a, logic [31:0] b, output logic [31:0] sum);
        logic [32:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        sum  = wide[31:0];
        fn_q = sum[31];
        fz_q = (sum == 32'd0);
        fv_q = (a[31] == b[31]) && (sum[31] != a[31]);
        fc_q = wide[32];
    endtask

    task automatic sub_flags(logic [31:0] a, logic [31:0] b, output logic [31:0] diff);
        diff = a - b;
        fn_q = diff[31];
        fz_q = (diff == 32'd0);
        fv_q = (a[31] != b[31]) && (diff[31] != a[31]);
        fc_q = (b > a);
    endtask

    // Advance the architectural state by one item and build its result.
    task automatic execute_item(logic f, logic [31:0] iw, logic [31:0] ld,
                                output result_t res);
        logic [5:0]  op, fcode;
        logic [4:0]  rs, rt, rd;
        logic [31:0] a, b, imm, simm, npc, addr, val;
        logic [7:0]  lane_byte;
        logic        known;
        res = '0;
        if (!halt_q && f && load_kind != LOAD_NONE) begin
            val = ld;
            if (load_kind == LOAD_BYTE) begin
                lane_byte = ld[load_lane*8 +: 8];
                val = {{24{lane_byte[7]}}, lane_byte};
            end
            write_gpr(load_reg, val);
            load_kind = LOAD_NONE;
            load_reg  = '0;
            load_lane = '0;
        end else if (!halt_q && !f && load_kind == LOAD_NONE) begin
            op    = iw[31:26];
            fcode = iw[5:0];
            rs = iw[25:21]; rt = iw[20:16]; rd = iw[15:11];
            a = read_gpr(rs);
            b = read_gpr(rt);
            imm  = {16'd0, iw[15:0]};
            simm = {{16{iw[15]}}, iw[15:0]};
            npc  = pc + 32'd4;
            addr = a + simm;
            known = 1'b1;
            case (op)
                OP_RTYPE:
                    case (fcode)
                        FN_ADD, FN_ADDU: begin add_flags(a, b, val); write_gpr(rd, val); end
                        FN_SUB, FN_SUBU: begin sub_flags(a, b, val); write_gpr(rd, val); end
                        FN_SLT:  write_gpr(rd, {31'd0, $signed(a) < $signed(b)});
                        FN_SLTU: write_gpr(rd, {31'd0, a < b});
                        FN_JR:   npc = a;
                        default: known = 1'b0;
                    endcase
                OP_LUI:   write_gpr(rt, {iw[15:0], 16'd0});
                OP_ORI:   write_gpr(rt, a | imm);
                OP_ADDI, OP_ADDIU: begin add_flags(a, simm, val); write_gpr(rt, val); end
                OP_SLTI:  write_gpr(rt, {31'd0, $signed(a) < $signed(simm)});
                OP_SLTIU: write_gpr(rt, {31'd0, a < imm});
                OP_LW, OP_LB: begin
                    res.mem_op   = MEM_READ;
                    res.mem_addr = addr;
                    load_kind = (op == OP_LW) ? LOAD_WORD : LOAD_BYTE;
                    load_reg  = rt;
                    load_lane = (op == OP_LB) ? addr[1:0] : 2'd0;
                end
                OP_SW: begin
                    res.mem_op = MEM_WRITE; res.mem_addr = addr;
                    res.mem_wdata = b; res.byte_enable = 4'hF;
                end
                OP_SB: begin
                    res.mem_op = MEM_WRITE; res.mem_addr = addr;
                    res.mem_wdata = {4{b[7:0]}};
                    res.byte_enable = 4'b0001 << addr[1:0];
                end
                OP_BEQ: if (a == b) begin fz_q = 1'b1; npc = npc + (simm << 2); end
                OP_BNE: if (a != b) begin fz_q = 1'b0; npc = npc + (simm << 2); end
                OP_BGTZ: if ($signed(a) > 0) npc = npc + (simm << 2);
                OP_J:   npc = {pc[31:28], iw[25:0], 2'b00};
                OP_JAL: begin
                    write_gpr(LINK_REG, pc + 32'd4);
                    npc = {pc[31:28], iw[25:0], 2'b00};
                end
                default: known = 1'b0;
            endcase
            if (known)
                pc = npc;
            else
                halt_q = 1'b1;
        end
        res.next_pc = pc;
        res.halted  = halt_q;
        res.flag_n  = fn_q;
        res.flag_z  = fz_q;
        res.flag_v  = fv_q;
        res.flag_c  = fc_q;
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t r;
        if (!rst_n) begin
            foreach (gpr[i]) gpr[i] = '0;
            pc = '0;
            {fn_q, fz_q, fv_q, fc_q} = '0;
            halt_q = 1'b0;
            load_kind = LOAD_NONE;
            load_reg = '0;
            load_lane = '0;
            due_q.delete();
            fail_count = 0;
            checked = 0;
        end else begin
            // Compare first so a result never meets its own expectation early.
            if (pop && !empty) begin
                if (due_q.size() == 0) begin
                    $error("result with no transaction outstanding, next_pc 0x%08h", next_pc);
                    fail_count++;
                end else begin
                    r = due_q.pop_front();
                    checked++;
                    check_field("next_pc", r.next_pc, next_pc);
                    check_field("mem_op", r.mem_op, mem_op);
                    check_field("mem_addr", r.mem_addr, mem_addr);
                    check_field("mem_wdata", r.mem_wdata, mem_wdata);
                    check_field("byte_enable", r.byte_enable, byte_enable);
                    check_field("halted", r.halted, halted);
                    check_field("flag_n", r.flag_n, flag_n);
                    check_field("flag_z", r.flag_z, flag_z);
                    check_field("flag_v", r.flag_v, flag_v);
                    check_field("flag_c", r.flag_c, flag_c);
                end
            end
            if (start_pc_we)
                pc = start_pc_wdata;
            if (push && !full) begin
                execute_item(func, instr_word, load_data, r);
                due_q.push_back(r);
            end
        end
    end
endmodule
`default_nettype wire

[bench/tb.sv]
// Testbench top: stimulus, idling, configuration phases and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import msc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start_pc_we = 1'b0;
    logic [31:0] start_pc_wdata = '0;
    logic        push = 1'b0;
    logic        func = 1'b0;
    logic [31:0] instr_word = '0;
    logic [31:0] load_data = '0;
    logic        pop = 1'b0;
    logic        full, empty;
    logic [31:0] next_pc, mem_addr, mem_wdata;
    logic [1:0]  mem_op;
    logic [3:0]  byte_enable;
    logic        halted, flag_n, flag_z, flag_v, flag_c;

    int fail_count, waiting, checked;
    int cycles = 0;
    int sent = 0;
    int pc_writes = 0;
    int stall_left = 0;
    // When set, neither side idles: back-to-back transactions.
    bit quiet = 1'b0;
    // Tracks whether the last instruction sent opened a load.
    bit load_open = 1'b0;

    mips_subset_execute_core u_top (
        .clk, .rst_n, .start_pc_we, .start_pc_wdata,
        .push, .full, .func, .instr_word, .load_data,
        .empty, .pop, .next_pc, .mem_op, .mem_addr, .mem_wdata,
        .byte_enable, .halted, .flag_n, .flag_z, .flag_v, .flag_c
    );

    msc_checker u_check (
        .clk, .rst_n, .start_pc_we, .start_pc_wdata,
        .push, .full, .func, .instr_word, .load_data,
        .empty, .pop, .next_pc, .mem_op, .mem_addr, .mem_wdata,
        .byte_enable, .halted, .flag_n, .flag_z, .flag_v, .flag_c,
        .fail_count, .waiting, .checked
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run with an error once the cycle count passes CYCLE_LIMIT.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Result side: mostly ready, short random stalls, now and then a long one.
    always @(posedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (!rst_n)
            pop <= 1'b0;
        else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else if (quiet)
            pop <= 1'b1;
        else if (r < 3) begin
            stall_left = $urandom_range(10, 40);
            pop <= 1'b0;
        end else
            pop <= (r >= 25);
    end

    function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                          logic [5:0] fcode);
        return {OP_RTYPE, rs, rt, rd, 5'($urandom), fcode};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic bit is_known(logic [31:0] iw);
        case (iw[31:26])
            OP_RTYPE:
                return iw[5:0] inside {FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_SLT,
                                       FN_SLTU, FN_JR};
            OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI,
            OP_SLTIU, OP_ORI, OP_LUI, OP_LB, OP_LW, OP_SB, OP_SW:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // Hand one transaction to the core; hold it until accepted.
    task automatic send(logic f, logic [31:0] iw, logic [31:0] ld);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < 20)
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        func <= f;
        instr_word <= iw;
        load_data <= ld;
        do @(posedge clk); while (full);
        sent++;
        if (!f && !load_open && iw[31:26] inside {OP_LW, OP_LB})
            load_open = 1'b1;
        else if (f && load_open)
            load_open = 1'b0;
    endtask

    task automatic instr(logic [31:0] iw);
        send(1'b0, iw, $urandom);
    endtask

    task automatic data(logic [31:0] ld);
        send(1'b1, $urandom, ld);
    endtask

    // Let the core drain, then load a new start PC while it is idle.
    task automatic set_start_pc(logic [31:0] value);
        push <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        start_pc_we <= 1'b1;
        start_pc_wdata <= value;
        @(posedge clk);
        start_pc_we <= 1'b0;
        pc_writes++;
    endtask

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 7)) : 5'($urandom);
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Build one recognised instruction with random fields.
    function automatic logic [31:0] rand_instr();
        logic [5:0] fns [7];
        logic [5:0] ops [15];
        fns = '{FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_SLT, FN_SLTU, FN_JR};
        ops = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI,
                OP_SLTIU, OP_ORI, OP_LUI, OP_LB, OP_LW, OP_SB, OP_SW};
        if ($urandom_range(0, 2) == 0)
            return enc_r(pick_reg(), pick_reg(), pick_reg(), fns[$urandom_range(0, 6)]);
        return enc_i(ops[$urandom_range(0, 14)], pick_reg(), pick_reg(), pick_imm());
    endfunction

    // Mostly well-formed streams: a load is followed by its data, with a
    // little noise of stray data and instructions sent into a pending load.
    task automatic run_random(int count);
        repeat (count) begin
            if (load_open) begin
                if ($urandom_range(0, 9) != 0)
                    data($urandom);
                else
                    instr(rand_instr());
            end else if ($urandom_range(0, 99) < 6)
                data($urandom);
            else
                instr(rand_instr());
        end
    endtask

    initial
    begin
        logic [31:0] bad;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: flag extremes, every operation, load corner cases.
        quiet = 1'b1;
        set_start_pc(32'h0000_0000);
        instr(enc_i(OP_LUI, 5'd0, 5'd1, 16'h7FFF));
        instr(enc_i(OP_ORI, 5'd1, 5'd1, 16'hFFFF));
        instr(enc_i(OP_ADDI, 5'd0, 5'd2, 16'h0001));
        instr(enc_r(5'd1, 5'd2, 5'd3, FN_ADD));
        instr(enc_r(5'd3, 5'd3, 5'd4, FN_ADDU));
        instr(enc_r(5'd0, 5'd2, 5'd5, FN_SUB));
        instr(enc_r(5'd1, 5'd1, 5'd6, FN_SUBU));
        instr(enc_r(5'd3, 5'd2, 5'd7, FN_SLT));
        instr(enc_r(5'd3, 5'd2, 5'd8, FN_SLTU));
        instr(enc_i(OP_SLTI, 5'd5, 5'd9, 16'hFFFF));
        instr(enc_i(OP_SLTIU, 5'd0, 5'd10, 16'hFFFF));
        instr(enc_i(OP_ADDIU, 5'd5, 5'd0, 16'h8000));
        instr(enc_i(OP_SW, 5'd3, 5'd1, 16'h7FFF));
        instr(enc_i(OP_SB, 5'd2, 5'd5, 16'h0002));
        data(32'hDEAD_BEEF);
        instr(enc_i(OP_LW, 5'd1, 5'd12, 16'h8001));
        instr(enc_i(OP_LUI, 5'd0, 5'd13, 16'h1234));
        data(32'hDEAD_BEEF);
        instr(enc_i(OP_LB, 5'd2, 5'd13, 16'h0001));
        data(32'h0080_0000);
        instr(enc_i(OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
        instr(enc_i(OP_BNE, 5'd1, 5'd2, 16'h0002));
        instr(enc_i(OP_BGTZ, 5'd1, 5'd0, 16'h0003));
        instr(enc_i(OP_BGTZ, 5'd5, 5'd0, 16'h0003));
        instr({OP_JAL, 26'h3FF_FFFF});
        instr({OP_J, 26'h000_0004});
        instr(enc_r(5'd31, 5'd0, 5'd0, FN_JR));

        // Random phases under different start PCs and idling.
        set_start_pc(32'hFFFF_FFFC);
        run_random(300);
        quiet = 1'b0;
        set_start_pc({30'($urandom_range(0, 32'h3FFF_FFFF)), 2'b00});
        run_random(350);
        set_start_pc(32'h7FFF_FFFC);
        run_random(350);
        set_start_pc({30'($urandom_range(0, 32'h3FFF_FFFF)), 2'b00});
        run_random(300);

        // Halt last: close any open load, stop the core, then confirm it
        // ignores everything that follows.
        if (load_open)
            data($urandom);
        do bad = $urandom; while (is_known(bad));
        instr(bad);
        run_random(15);
        data($urandom);
        push <= 1'b0;

        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("tb: %0d transactions sent, %0d results checked, %0d start PC loads",
                 sent, checked, pc_writes);
        $display("tb: covered all opcodes, load corner cases, flag extremes and halt");
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
`default_nettype wire
